FILE: rtl/fqs_pkg.sv
// Shared types and codes for the FIFO queue with content search.
// No dependencies; imported by every module of the block except fqs_ram.
package fqs_pkg;

    // Default number of entries held by the queue
    localparam int DEPTH_DEF = 32;

    // Fixed field widths of the transaction payloads
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;

    // Operation codes carried by the mode field
    localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd4;

    // Input transaction
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          occupancy;
        logic                      last;
    } t_out_item;

endpackage

FILE: rtl/fifo_queue_with_search.sv
// FIFO queue of signed words with content search. Enqueue, error and unused-mode
// results appear in the cycle after acceptance; a dequeue result passes through the RAM
// read register and then the output register. Search of n held words: one entry compared
// per cycle through a single comparator, pausing while a match waits for the output register.
// One transaction is in flight at a time; the next is taken once the block is idle.
// Synchronous active-low reset empties the queue; the entry RAM itself is not cleared.
// Depends on fqs_pkg and fqs_ram.
module fifo_queue_with_search #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fqs_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fqs_pkg::t_out_item o_out_data
);

    import fqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEQ  = 4'b0010,
        S_SRCH = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_addr, n_addr;
    logic [VALUE_W-1:0]   r_key, n_key;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 in_acc;
    logic                 out_free;
    logic                 hit;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [VALUE_W-1:0]   rd_data;

    // Circular pointer steps
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    // Entry storage
    fqs_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(i_in_data.value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    // Shared comparator
    assign hit        = (rd_data == r_key);

    // Sequencer and result formation
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode)
                        MODE_ENQ: begin
                            n_out_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_out = '{status: ST_FULL, data: '0, position: '0,
                                          occupancy: POS_W'(r_count), last: 1'b1};
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = ptr_inc(r_tail);
                                n_count = r_count + 1'b1;
                                n_out   = '{status: ST_OK, data: '0, position: '0,
                                            occupancy: POS_W'(r_count + 1'b1), last: 1'b1};
                            end
                        end
                        MODE_DEQ: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_EMPTY, data: '0, position: '0,
                                          occupancy: '0, last: 1'b1};
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = S_DEQ;
                            end
                        end
                        MODE_SRCH: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_DONE, data: '0, position: '0,
                                          occupancy: '0, last: 1'b1};
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = ptr_dec(r_tail);
                                n_addr  = ptr_dec(r_tail);
                                n_idx   = r_count;
                                n_key   = i_in_data.value;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out = '{status: ST_OK, data: '0, position: '0,
                                      occupancy: POS_W'(r_count), last: 1'b1};
                        end
                    endcase
                end
            end
            S_DEQ: begin
                // Output register is empty here: it was free when the transaction was taken
                n_out_valid = 1'b1;
                n_out = '{status: ST_OK, data: rd_data, position: '0,
                          occupancy: POS_W'(r_count - 1'b1), last: 1'b1};
                n_count = r_count - 1'b1;
                n_head  = ptr_inc(r_head);
                n_state = S_IDLE;
            end
            S_SRCH: begin
                // Advance unless a match must wait for the output register
                if (!hit || out_free) begin
                    if (hit) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: ST_MATCH, data: '0, position: POS_W'(r_idx),
                                  occupancy: POS_W'(r_count), last: 1'b0};
                    end
                    if (r_idx == CW'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_dec(r_addr);
                        n_addr  = ptr_dec(r_addr);
                        n_idx   = r_idx - 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_DONE, data: '0, position: '0,
                              occupancy: POS_W'(r_count), last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_key  <= n_key;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/fqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold the last word when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fqs_check.sv
// Port-level checker for the FIFO queue with content search, bound to the top level.
// Depends on fqs_pkg.
module fqs_check #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fqs_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fqs_pkg::t_out_item o_out_data
);

    import fqs_pkg::*;

    logic in_acc;
    logic out_end;
    logic r_busy;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_end = o_out_valid && !i_out_stall && o_out_data.last;

    // Track a transaction whose final result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= (r_busy && !out_end) || in_acc;
        end
    end

    // Hold a stalled input transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Take no transaction while one is still in flight
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_busy || out_end)
        else $error("transaction accepted while busy");

    // Show no result without a transaction in flight
    a_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_busy)
        else $error("result without transaction");

    // Only match results precede the final one; occupancy stays in range
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last || o_out_data.status == ST_MATCH) &&
                        (o_out_data.occupancy <= POS_W'(DEPTH)))
        else $error("bad result fields");

endmodule

bind fifo_queue_with_search fqs_check #(.DEPTH(DEPTH)) u_fqs_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

FILE: tb/fqs_checker.sv
// Checker for fifo_queue_with_search: predicts results from accepted input
// transactions and compares each accepted result with the oldest prediction.
// Depends on fqs_pkg.
module fqs_checker #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  fqs_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  fqs_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    // Predicted queue contents; entry 0 is the head
    logic signed [VALUE_W-1:0] held_words [DEPTH];
    int                        held_count;
    t_out_item                 awaited_results [$];
    int                        fail_total;

    // Apply one operation to the predicted queue and queue its results
    task automatic predict_outcome(input t_in_item txn);
        t_out_item fin;
        t_out_item hit;
        int        k;
        fin      = '0;
        fin.last = 1'b1;
        case (txn.mode)
            MODE_ENQ: begin
                if (held_count >= DEPTH) begin
                    fin.status = ST_FULL;
                end else begin
                    held_words[held_count] = txn.value;
                    held_count++;
                    fin.status = ST_OK;
                end
            end
            MODE_DEQ: begin
                if (held_count == 0) begin
                    fin.status = ST_EMPTY;
                end else begin
                    fin.data = held_words[0];
                    for (k = 0; k + 1 < held_count; k++)
                        held_words[k] = held_words[k + 1];
                    held_count--;
                    fin.status = ST_OK;
                end
            end
            MODE_SRCH: begin
                // scan from the newest entry back to the head
                for (k = held_count; k > 0; k--) begin
                    if (held_words[k - 1] == txn.value) begin
                        hit           = '0;
                        hit.status    = ST_MATCH;
                        hit.position  = POS_W'(k);
                        hit.occupancy = POS_W'(held_count);
                        awaited_results.push_back(hit);
                    end
                end
                fin.status = ST_DONE;
            end
            default: begin
                // unused mode: acknowledge and leave the queue alone
                fin.status = ST_OK;
            end
        endcase
        fin.occupancy = POS_W'(held_count);
        awaited_results.push_back(fin);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        logic      bad;
        if (!i_rst_n) begin
            held_count = 0;
            awaited_results.delete();
        end else begin
            // check an accepted result against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display({"%0t: unexpected result: status %0d data %0d pos %0d ",
                                  "occ %0d last %0d"},
                                 $realtime, i_out_data.status, i_out_data.data,
                                 i_out_data.position, i_out_data.occupancy,
                                 i_out_data.last);
                end else begin
                    want = awaited_results.pop_front();
                    bad  = (i_out_data.status    !== want.status)    ||
                           (i_out_data.data      !== want.data)      ||
                           (i_out_data.position  !== want.position)  ||
                           (i_out_data.occupancy !== want.occupancy) ||
                           (i_out_data.last      !== want.last);
                    if (bad) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: mismatch: expected status %0d data %0d pos %0d ",
                                      "occ %0d last %0d, got status %0d data %0d pos %0d ",
                                      "occ %0d last %0d"},
                                     $realtime, want.status, want.data, want.position,
                                     want.occupancy, want.last, i_out_data.status,
                                     i_out_data.data, i_out_data.position,
                                     i_out_data.occupancy, i_out_data.last);
                    end
                end
            end
            // predict the results of an accepted input transaction
            if (i_in_valid && !i_in_stall)
                predict_outcome(i_in_data);
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

FILE: tb/tb_top.sv
// Top of the testbench for fifo_queue_with_search: clock, reset, stimulus and
// verdict. Depends on fqs_pkg, the block itself and fqs_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fqs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    // Small pool of words so that searches find repeated matches
    logic signed [VALUE_W-1:0] word_pool [6];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fifo_queue_with_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    fqs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_txn(input logic [MODE_W-1:0] mode,
                            input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: mode, value: value};
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and hold off until every predicted result has come back
    task automatic wait_for_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Random transactions with a given mix; unused-mode ones are not counted
    task automatic run_segment(input int n, input int enq_pct, input int deq_pct);
        int                        done_cnt;
        int                        r;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        done_cnt = 0;
        while (done_cnt < n) begin
            r = $urandom_range(0, 99);
            if (r < 3)                          mode = MODE_UNUSED;
            else if (r < 3 + enq_pct)           mode = MODE_ENQ;
            else if (r < 3 + enq_pct + deq_pct) mode = MODE_DEQ;
            else                                mode = MODE_SRCH;
            if ($urandom_range(0, 9) < 7)
                value = word_pool[$urandom_range(0, 5)];
            else
                value = $signed($urandom);
            send_txn(mode, value);
            if (mode != MODE_UNUSED)
                done_cnt++;
        end
    endtask

    // Result-side back-pressure: free stretches, short and long stalls
    initial begin
        int free_len;
        int stall_len;
        forever begin
            free_len  = $urandom_range(1, 8);
            stall_len = pick_gap();
            if ($urandom_range(0, 5) == 0) begin
                free_len  = $urandom_range(30, 80);
                stall_len = 0;
            end
            repeat (free_len) begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat (stall_len) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    // Guard against a hung run
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        word_pool[0] = '0;
        word_pool[1] = -32'sd1;
        word_pool[2] = WORD_MIN;
        word_pool[3] = WORD_MAX;
        word_pool[4] = 32'sd5;
        word_pool[5] = 32'sd77;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: errors on an empty queue, extremes, repeated matches
        send_txn(MODE_DEQ, '0);
        send_txn(MODE_SRCH, '0);
        send_txn(MODE_UNUSED, WORD_MAX);
        send_txn(MODE_ENQ, WORD_MIN);
        send_txn(MODE_ENQ, WORD_MAX);
        send_txn(MODE_ENQ, '0);
        send_txn(MODE_ENQ, -32'sd1);
        send_txn(MODE_ENQ, WORD_MIN);
        send_txn(MODE_SRCH, WORD_MIN);
        send_txn(MODE_SRCH, 32'sd12345);
        send_txn(MODE_UNUSED, WORD_MIN);
        send_txn(MODE_SRCH, -32'sd1);
        send_txn(MODE_DEQ, '0);
        send_txn(MODE_DEQ, WORD_MAX);
        send_txn(MODE_SRCH, WORD_MIN);

        // Random: fill to the top, churn, drain past empty, then mix
        run_segment(50, 75, 10);
        wait_for_quiet();
        run_segment(30, 40, 35);
        run_segment(40, 12, 70);
        wait_for_quiet();
        run_segment(10, 40, 40);

        wait_for_quiet();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
